### sv/qoi_pkg.sv
// Shared types, constants and helpers for the quaternion orientation integrator.
package qoi_pkg;

    localparam int unsigned CompW = 32;
    localparam logic signed [CompW-1:0] OneQ28 = 32'sh1000_0000;

    typedef enum logic [1:0] {
        K_LOAD      = 2'd0,
        K_INTEGRATE = 2'd1,
        K_NORMALIZE = 2'd2,
        K_NONE      = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [CompW-1:0] load_real;
        logic signed [CompW-1:0] load_x;
        logic signed [CompW-1:0] load_y;
        logic signed [CompW-1:0] load_z;
        logic signed [CompW-1:0] rate_x;
        logic signed [CompW-1:0] rate_y;
        logic signed [CompW-1:0] rate_z;
        logic [CompW-1:0]        step_time;
    } t_in_item;

    typedef struct packed {
        logic signed [CompW-1:0] out_real;
        logic signed [CompW-1:0] out_x;
        logic signed [CompW-1:0] out_y;
        logic signed [CompW-1:0] out_z;
        logic                    zero_norm;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VEC,
        S_PROD,
        S_ADD,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_DIVSTORE,
        S_OUT
    } t_state;

    function automatic logic signed [CompW-1:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -68'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[CompW-1:0];
    endfunction

endpackage

### sv/qoi_if.sv
// Valid/ready channel carrying one item.
interface qoi_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/qoi_mul.sv
// Shared signed 33x33 multiplier with registered product.
module qoi_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

### sv/qoi_div.sv
// Restoring divider, one quotient bit per cycle, 61-bit dividend magnitude.
module qoi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [60:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [60:0] o_quo
);
    logic [60:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_try;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_try  = {r_rem[31:0], r_quo[60]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 6'd60;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, i_den}) begin
                n_rem = w_try - {1'b0, i_den};
                n_quo = {r_quo[59:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_quo = {r_quo[59:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == 6'd0) && !i_start;
    assign o_quo  = n_quo;
endmodule

### sv/quaternion_orientation_integrator.sv
// Top level: quaternion state with integrate and normalize sequencer.
//
//  channel | dir | payload                                  | accepted when
//  i_item  | in  | kind, load_*, rate_*, step_time           | valid & ready
//  o_item  | out | out_real, out_x, out_y, out_z, zero_norm   | valid & ready
//
// Load and unused kinds pass through the output state to a registered result.
// Integrate scales the rate vector, accumulates the twelve Hamilton terms through the
// one shared multiplier, adds half the product, then registers the result.
// Normalize sums the squares, takes the root bit by bit, then per component starts
// the serial divider and stores its quotient, then registers the result.
// Reset is synchronous: state returns to identity, no item is pending.
// The output register holds a result until taken; the next item is accepted
// only after that.
module quaternion_orientation_integrator (
    input  logic i_clk,
    input  logic i_rst_n,
    qoi_if.sink   i_item,
    qoi_if.source o_item
);
    import qoi_pkg::*;

    t_state r_state, n_state;
    logic signed [CompW-1:0] r_q [4];     // orientation real, x, y, z
    logic signed [CompW-1:0] r_v [3];     // scaled rate vector
    logic signed [67:0]      r_acc [4];   // product sums / square sum
    t_in_item r_in;
    logic [4:0] r_step;                   // operation index inside a phase
    logic       r_mvld;                   // multiplier output holds a valid product
    logic [4:0] r_mstep;
    logic [64:0] r_s;                     // square sum, later root remainder
    logic [64:0] r_root;
    logic [65:0] r_bit;
    logic [31:0] r_n;
    logic        r_zn;
    logic        r_ovld;
    t_out_item   r_out;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic        w_dstart, w_ddone;
    logic [60:0] w_dnum, w_dquo;
    logic signed [CompW-1:0] w_c;
    logic [31:0] w_mag;

    qoi_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    qoi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
                   .i_num(w_dnum), .i_den(r_n), .o_done(w_ddone), .o_quo(w_dquo));

    assign i_item.ready = (r_state == S_IDLE) && !r_ovld;
    assign o_item.valid = r_ovld;
    assign o_item.data  = r_out;

    // Hamilton term table: which v, which q, sign, target component.
    function automatic void term(input logic [4:0] k, output logic [1:0] vi,
                                 output logic [1:0] qi, output logic neg,
                                 output logic [1:0] dst);
        case (k)
            5'd0:  begin vi = 2'd0; qi = 2'd1; neg = 1'b1; dst = 2'd0; end
            5'd1:  begin vi = 2'd1; qi = 2'd2; neg = 1'b1; dst = 2'd0; end
            5'd2:  begin vi = 2'd2; qi = 2'd3; neg = 1'b1; dst = 2'd0; end
            5'd3:  begin vi = 2'd0; qi = 2'd0; neg = 1'b0; dst = 2'd1; end
            5'd4:  begin vi = 2'd1; qi = 2'd3; neg = 1'b0; dst = 2'd1; end
            5'd5:  begin vi = 2'd2; qi = 2'd2; neg = 1'b1; dst = 2'd1; end
            5'd6:  begin vi = 2'd1; qi = 2'd0; neg = 1'b0; dst = 2'd2; end
            5'd7:  begin vi = 2'd2; qi = 2'd1; neg = 1'b0; dst = 2'd2; end
            5'd8:  begin vi = 2'd0; qi = 2'd3; neg = 1'b1; dst = 2'd2; end
            5'd9:  begin vi = 2'd2; qi = 2'd0; neg = 1'b0; dst = 2'd3; end
            5'd10: begin vi = 2'd0; qi = 2'd2; neg = 1'b0; dst = 2'd3; end
            default: begin vi = 2'd1; qi = 2'd1; neg = 1'b1; dst = 2'd3; end
        endcase
    endfunction

    logic [1:0] w_vi, w_qi, w_dst, w_mvi, w_mqi, w_mdst;
    logic       w_neg, w_mneg;
    always_comb begin
        term(r_step, w_vi, w_qi, w_neg, w_dst);
        term(r_mstep, w_mvi, w_mqi, w_mneg, w_mdst);
    end

    // Feed the multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_VEC: begin
                w_ma = (r_step == 5'd0) ? 33'(r_in.rate_x) :
                       (r_step == 5'd1) ? 33'(r_in.rate_y) : 33'(r_in.rate_z);
                w_mb = {1'b0, r_in.step_time};
            end
            S_PROD: begin
                w_ma = 33'(r_v[w_vi]);
                w_mb = 33'(r_q[w_qi]);
            end
            S_SQ: begin
                w_ma = 33'(r_q[r_step[1:0]]);
                w_mb = 33'(r_q[r_step[1:0]]);
            end
            default: ;
        endcase
    end

    // Divide the component magnitude scaled by 2^28; the sign is restored on store.
    assign w_c      = r_q[r_step[1:0]];
    assign w_mag    = w_c[31] ? 32'(-w_c) : 32'(w_c);
    assign w_dnum   = {1'b0, w_mag, 28'd0};
    assign w_dstart = (r_state == S_DIV) && !r_mvld;

    logic [65:0] w_trial;
    assign w_trial = {1'b0, r_root} + r_bit;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_item.valid && i_item.ready) begin
                case (t_kind'(i_item.data.kind))
                    K_INTEGRATE: n_state = S_VEC;
                    K_NORMALIZE: n_state = S_SQ;
                    default:     n_state = S_OUT;
                endcase
            end
            S_VEC:  if (r_step == 5'd3) n_state = S_PROD;
            S_PROD: if (r_step == 5'd12) n_state = S_ADD;
            S_ADD:  n_state = S_OUT;
            S_SQ:   if (r_step == 5'd4) n_state = S_SQRT;
            S_SQRT: if (r_bit == '0) n_state = S_DIV;
            S_DIV:  n_state = (r_n == '0) ? S_OUT : S_DIVSTORE;
            S_DIVSTORE: if (w_ddone) n_state = (r_step == 5'd3) ? S_OUT : S_DIV;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_q[0]  <= OneQ28;
            r_q[1]  <= '0;
            r_q[2]  <= '0;
            r_q[3]  <= '0;
            r_mvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_item.valid && o_item.ready) r_ovld <= 1'b0;
            r_mvld  <= (r_state == S_VEC && r_step < 5'd3) ||
                       (r_state == S_PROD && r_step < 5'd12) ||
                       (r_state == S_SQ && r_step < 5'd4);
            r_mstep <= r_step;
            case (r_state)
                S_IDLE: if (i_item.valid && i_item.ready) begin
                    r_in   <= i_item.data;
                    r_step <= '0;
                    r_zn   <= 1'b0;
                    for (int i = 0; i < 4; i++) r_acc[i] <= '0;
                    if (t_kind'(i_item.data.kind) == K_LOAD) begin
                        r_q[0] <= i_item.data.load_real;
                        r_q[1] <= i_item.data.load_x;
                        r_q[2] <= i_item.data.load_y;
                        r_q[3] <= i_item.data.load_z;
                    end
                end
                S_VEC: begin
                    if (r_mvld) r_v[r_mstep[1:0]] <= sat32(68'(w_mp >>> 20));
                    r_step <= (r_step == 5'd3) ? 5'd0 : r_step + 5'd1;
                end
                S_PROD: begin
                    if (r_mvld) begin
                        if (w_mneg) r_acc[w_mdst] <= r_acc[w_mdst] - 68'(w_mp >>> 28);
                        else        r_acc[w_mdst] <= r_acc[w_mdst] + 68'(w_mp >>> 28);
                    end
                    r_step <= r_step + 5'd1;
                end
                S_ADD: begin
                    for (int i = 0; i < 4; i++)
                        r_q[i] <= sat32(68'(r_q[i]) + (r_acc[i] >>> 1));
                end
                S_SQ: begin
                    if (r_mvld) r_acc[0] <= r_acc[0] + 68'(w_mp);
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd4) begin
                        r_s    <= (r_acc[0] + 68'(w_mp) > 68'h0_FFFF_FFFF_FFFF_FFFF) ?
                                  65'h0_FFFF_FFFF_FFFF_FFFF : 65'(r_acc[0] + 68'(w_mp));
                        r_root <= '0;
                        r_bit  <= 66'h1 << 62;
                        r_step <= '0;
                    end
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if ({1'b0, r_s} >= w_trial) begin
                            r_s    <= 65'({1'b0, r_s} - w_trial);
                            r_root <= 65'((66'(r_root) >> 1) + r_bit);
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_n <= r_root[31:0];
                    end
                end
                S_DIV: if (r_n == '0) begin
                    r_q[0] <= OneQ28;
                    r_zn   <= 1'b1;
                end
                S_DIVSTORE: if (w_ddone) begin
                    r_q[r_step[1:0]] <= w_c[31] ? sat32(-68'(w_dquo)) : sat32(68'(w_dquo));
                    r_step <= r_step + 5'd1;
                end
                S_OUT: begin
                    r_ovld <= 1'b1;
                    r_out  <= '{out_real: r_q[0], out_x: r_q[1], out_y: r_q[2],
                               out_z: r_q[3], zero_norm: r_zn};
                end
                default: ;
            endcase
        end
    end
endmodule

### sv/qoi_checker.sv
// Port-level checker for the quaternion orientation integrator.
module qoi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input qoi_pkg::t_out_item out_data
);
    import qoi_pkg::*;

    a_no_accept_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_not_ready_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind quaternion_orientation_integrator qoi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_item.valid), .in_ready(i_item.ready),
    .out_valid(o_item.valid), .out_ready(o_item.ready), .out_data(o_item.data)
);
